// ===== rtl/core/dvfa_pkg.sv =====
// ----------------------------------------------------------------------------
// dvfa_pkg - shared definitions for the DV isochronous frame assembler
// Constants of the packet format, result codes and the word passed from the
// front end to the back end through the queue.
// ----------------------------------------------------------------------------
package dvfa_pkg;

  // Packet format
  localparam int PAYLOAD_BYTES  = 480;
  localparam int PAYLOAD_QUADS  = PAYLOAD_BYTES / 4;
  localparam int LAST_INDEX     = 1 + PAYLOAD_QUADS;
  localparam int FULL_LENGTH    = PAYLOAD_BYTES + 8;
  localparam int HEADER_LENGTH  = 8;
  localparam int CIP_DBS        = 120;
  localparam int INDEX_BITS     = 7;
  localparam int ADDR_BITS      = 18;
  localparam int SIZE_BITS      = 18;

  localparam logic [SIZE_BITS-1:0] FRAME_SIZE_RST = 18'd120000;

  // Frame event codes
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_COMPLETE  = 2'd1,
    EV_UNDERFLOW = 2'd2,
    EV_OVERFLOW  = 2'd3
  } frame_event_t;

  // Packet error codes
  typedef enum logic [1:0] {
    PERR_NONE    = 2'd0,
    PERR_BAD_LEN = 2'd1,
    PERR_BAD_CIP = 2'd2
  } packet_error_t;

  // Classified word, front end to back end
  typedef struct packed {
    logic                  first;     // first quadlet of a packet
    logic [INDEX_BITS-1:0] idx;       // quadlet index within the packet
    logic                  len_ok;    // length status 8 or 488
    logic                  len_full;  // length status 488
    logic                  hdr0_ok;   // CIP header 0 pattern and DBS
    logic                  hdr1_ok;   // CIP header 1 top bits 100b
    logic                  block0;    // DIF header marks block 0
    logic [31:0]           quadlet;
  } class_t;

endpackage

// ===== rtl/core/dvfa_if.sv =====
// ----------------------------------------------------------------------------
// dvfa_if - stream interfaces of the DV frame assembler
// Input channel carries received quadlets, output channel carries the
// per-quadlet result word (buffer write and frame/packet status).
// ----------------------------------------------------------------------------
interface dvfa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] quadlet;
  logic        first_word;
  logic [15:0] packet_length;

  modport source (output valid, output quadlet, output first_word,
                  output packet_length, input ready);
  modport sink   (input valid, input quadlet, input first_word,
                  input packet_length, output ready);
endinterface

interface dvfa_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [17:0] write_address;
  logic [31:0] write_data;
  logic [1:0]  frame_event;
  logic [1:0]  packet_error;
  logic [31:0] frame_sequence;

  modport source (output valid, output write_enable, output write_address,
                  output write_data, output frame_event, output packet_error,
                  output frame_sequence, input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input write_data, input frame_event, input packet_error,
                  input frame_sequence, output ready);
endinterface

// ===== rtl/core/dvfa_front.sv =====
// ----------------------------------------------------------------------------
// dvfa_front - quadlet classifier
// Tracks the quadlet index within the packet and evaluates the length status
// and header patterns of every accepted word, pushing the result to the queue.
// ----------------------------------------------------------------------------
module dvfa_front (
  input  logic              clk,
  input  logic              rst_n,
  dvfa_in_if.sink           in_chan,
  output logic              enq_valid,
  input  logic              enq_ready,
  output dvfa_pkg::class_t  enq_data
);

  logic [dvfa_pkg::INDEX_BITS-1:0] word_index_r, word_index_nxt;
  logic [dvfa_pkg::INDEX_BITS-1:0] idx;
  logic                            fire;

  assign in_chan.ready = enq_ready;
  assign enq_valid     = in_chan.valid;
  assign fire          = in_chan.valid & enq_ready;

  // Index of this word; a first word restarts the count
  assign idx = in_chan.first_word ? '0 : word_index_r;

  // Next index saturates at all ones
  always_comb begin
    if (idx == {dvfa_pkg::INDEX_BITS{1'b1}}) begin
      word_index_nxt = idx;
    end else begin
      word_index_nxt = idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r <= '0;
    end else if (fire) begin
      word_index_r <= word_index_nxt;
    end
  end

  // Classification of the word
  always_comb begin
    enq_data.first    = in_chan.first_word;
    enq_data.idx      = idx;
    enq_data.len_full = (in_chan.packet_length == 16'(dvfa_pkg::FULL_LENGTH));
    enq_data.len_ok   = enq_data.len_full ||
                        (in_chan.packet_length == 16'(dvfa_pkg::HEADER_LENGTH));
    enq_data.hdr0_ok  = (in_chan.quadlet[31:30] == 2'b00) &&
                        (in_chan.quadlet[23:16] == 8'(dvfa_pkg::CIP_DBS));
    enq_data.hdr1_ok  = (in_chan.quadlet[31:29] == 3'b100);
    enq_data.block0   = (in_chan.quadlet[31:29] == 3'b000) &&
                        (in_chan.quadlet[23:19] == 5'b00000);
    enq_data.quadlet  = in_chan.quadlet;
  end

endmodule

// ===== rtl/core/dvfa_queue.sv =====
// ----------------------------------------------------------------------------
// dvfa_queue - two-entry word queue
// Decouples the classifier from the frame tracker so either side may stall.
// ----------------------------------------------------------------------------
module dvfa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enq_valid,
  output logic              enq_ready,
  input  dvfa_pkg::class_t  enq_data,
  output logic              deq_valid,
  input  logic              deq_ready,
  output dvfa_pkg::class_t  deq_data
);

  dvfa_pkg::class_t entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic             pop;

  assign enq_ready = (count_r != 2'd2);
  assign deq_valid = (count_r != 2'd0);
  assign deq_data  = entry_r[rd_ptr_r];
  assign push      = enq_valid & enq_ready;
  assign pop       = deq_valid & deq_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= enq_data;
    end
  end

endmodule

// ===== rtl/core/dvfa_back.sv =====
// ----------------------------------------------------------------------------
// dvfa_back - packet acceptance and frame position tracker
// Holds the packet and frame state, the frame size register and the output
// register; produces one result word for every classified quadlet.
// ----------------------------------------------------------------------------
module dvfa_back #(
  parameter int POSITION_BITS = 18
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_enable,
  input  logic [dvfa_pkg::SIZE_BITS-1:0]      cfg_write_data,
  input  logic                                deq_valid,
  output logic                                deq_ready,
  input  dvfa_pkg::class_t                    deq_data,
  dvfa_out_if.source                          out_chan
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_SAT_LIMIT =
    POS_MAX - POSITION_BITS'(dvfa_pkg::PAYLOAD_BYTES);

  // Control state
  logic [dvfa_pkg::SIZE_BITS-1:0] frame_size_r;
  logic                           first_header_ok_r, first_header_ok_nxt;
  logic                           packet_accepted_r, packet_accepted_nxt;
  logic                           packet_writes_r, packet_writes_nxt;
  logic [POSITION_BITS-1:0]       frame_position_r, frame_position_nxt;
  logic                           seen_first_frame_r, seen_first_frame_nxt;
  logic [31:0]                    completed_frames_r, completed_frames_nxt;
  logic                           out_valid_r;

  // Result register
  logic                           we_r, we_nxt;
  logic [dvfa_pkg::ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [31:0]                    data_r, data_nxt;
  dvfa_pkg::frame_event_t         ev_r, ev_nxt;
  dvfa_pkg::packet_error_t        perr_r, perr_nxt;
  logic [31:0]                    seq_r, seq_nxt;

  logic                           pop;
  logic [POSITION_BITS-1:0]       pos_eff;
  logic [POSITION_BITS-1:0]       size_ext;
  logic [POSITION_BITS:0]         fit_sum;
  logic                           writes;
  logic [dvfa_pkg::INDEX_BITS-1:0] idx_m2;
  logic [dvfa_pkg::ADDR_BITS-1:0] offset;
  logic                           in_payload;

  assign pop       = deq_valid & (~out_valid_r | out_chan.ready);
  assign deq_ready = ~out_valid_r | out_chan.ready;

  assign size_ext  = POSITION_BITS'(frame_size_r);
  assign idx_m2    = deq_data.idx - 7'd2;
  assign offset    = {9'd0, idx_m2, 2'b00};
  assign in_payload = (deq_data.idx >= 7'd2) &&
                      (deq_data.idx <= 7'(dvfa_pkg::LAST_INDEX));

  // Per-word packet and frame update
  always_comb begin
    first_header_ok_nxt  = first_header_ok_r;
    packet_accepted_nxt  = packet_accepted_r;
    packet_writes_nxt    = packet_writes_r;
    frame_position_nxt   = frame_position_r;
    seen_first_frame_nxt = seen_first_frame_r;
    completed_frames_nxt = completed_frames_r;
    we_nxt   = 1'b0;
    addr_nxt = '0;
    data_nxt = '0;
    ev_nxt   = dvfa_pkg::EV_NONE;
    perr_nxt = dvfa_pkg::PERR_NONE;
    seq_nxt  = '0;
    pos_eff  = frame_position_r;
    writes   = packet_writes_r;
    fit_sum  = '0;

    priority if (deq_data.first) begin
      // Length status and CIP header 0
      packet_accepted_nxt = deq_data.len_ok;
      packet_writes_nxt   = deq_data.len_full;
      first_header_ok_nxt = deq_data.hdr0_ok;
      if (!deq_data.len_ok) begin
        perr_nxt = dvfa_pkg::PERR_BAD_LEN;
      end
    end else if (packet_accepted_r && (deq_data.idx == 7'd1)) begin
      // CIP header 1; header-only packets stop here
      if (!(first_header_ok_r && deq_data.hdr1_ok)) begin
        perr_nxt            = dvfa_pkg::PERR_BAD_CIP;
        packet_accepted_nxt = 1'b0;
      end else if (!packet_writes_r) begin
        packet_accepted_nxt = 1'b0;
      end
    end else if (packet_accepted_r && in_payload) begin
      // First payload quadlet: block 0 check and fit decision
      if (deq_data.idx == 7'd2) begin
        if (deq_data.block0) begin
          if (!seen_first_frame_r) begin
            seen_first_frame_nxt = 1'b1;
          end else if (frame_position_r < size_ext) begin
            ev_nxt = dvfa_pkg::EV_UNDERFLOW;
          end else if (frame_position_r > size_ext) begin
            ev_nxt = dvfa_pkg::EV_OVERFLOW;
          end else begin
            ev_nxt               = dvfa_pkg::EV_COMPLETE;
            seq_nxt              = completed_frames_r;
            completed_frames_nxt = completed_frames_r + 32'd1;
          end
          pos_eff = '0;
        end
        fit_sum = {1'b0, pos_eff} + (POSITION_BITS+1)'(dvfa_pkg::PAYLOAD_BYTES);
        writes  = (fit_sum <= (POSITION_BITS+1)'(frame_size_r));
        packet_writes_nxt = writes;
      end
      frame_position_nxt = pos_eff;
      if (writes) begin
        we_nxt   = 1'b1;
        addr_nxt = pos_eff[dvfa_pkg::ADDR_BITS-1:0] + offset;
        data_nxt = deq_data.quadlet;
      end
      // Last payload quadlet: advance the position, saturating
      if (deq_data.idx == 7'(dvfa_pkg::LAST_INDEX)) begin
        if (pos_eff > POS_SAT_LIMIT) begin
          frame_position_nxt = POS_MAX;
        end else begin
          frame_position_nxt = pos_eff + POSITION_BITS'(dvfa_pkg::PAYLOAD_BYTES);
        end
        packet_accepted_nxt = 1'b0;
      end
    end else begin
      // Word outside any accepted packet: ignored
      perr_nxt = dvfa_pkg::PERR_NONE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r       <= dvfa_pkg::FRAME_SIZE_RST;
      first_header_ok_r  <= 1'b0;
      packet_accepted_r  <= 1'b0;
      packet_writes_r    <= 1'b0;
      frame_position_r   <= '0;
      seen_first_frame_r <= 1'b0;
      completed_frames_r <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        frame_size_r <= cfg_write_data;
      end
      if (pop) begin
        first_header_ok_r  <= first_header_ok_nxt;
        packet_accepted_r  <= packet_accepted_nxt;
        packet_writes_r    <= packet_writes_nxt;
        frame_position_r   <= frame_position_nxt;
        seen_first_frame_r <= seen_first_frame_nxt;
        completed_frames_r <= completed_frames_nxt;
        out_valid_r        <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r        <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      we_r   <= we_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      ev_r   <= ev_nxt;
      perr_r <= perr_nxt;
      seq_r  <= seq_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.write_enable   = we_r;
  assign out_chan.write_address  = addr_r;
  assign out_chan.write_data     = data_r;
  assign out_chan.frame_event    = ev_r;
  assign out_chan.packet_error   = perr_r;
  assign out_chan.frame_sequence = seq_r;

endmodule

// ===== rtl/core/dv_isoc_frame_assembler.sv =====
// ----------------------------------------------------------------------------
// Path: an accepted quadlet is registered in the queue, then in the output register.
// Throughput: one quadlet per cycle while out_chan.ready holds; the frame
//   tracker sets the rate, with a two-entry queue between it and the classifier.
// Reset (rst_n low, synchronous): packet and frame state cleared, frame size
//   back to 120000 bytes, queue and output register emptied.
// ----------------------------------------------------------------------------
// dv_isoc_frame_assembler - DV isochronous frame assembler
// Checks received isochronous packets and writes DV payload into the frame
// buffer, reporting frame complete, underflow and overflow.
// ----------------------------------------------------------------------------
module dv_isoc_frame_assembler #(
  parameter int POSITION_BITS = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_enable,
  input  logic [dvfa_pkg::SIZE_BITS-1:0] cfg_write_data,
  dvfa_in_if.sink                        in_chan,
  dvfa_out_if.source                     out_chan
);

  logic             enq_valid;
  logic             enq_ready;
  dvfa_pkg::class_t enq_data;
  logic             deq_valid;
  logic             deq_ready;
  dvfa_pkg::class_t deq_data;

  // Classifier
  dvfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .enq_valid (enq_valid),
    .enq_ready (enq_ready),
    .enq_data  (enq_data)
  );

  // Decoupling queue
  dvfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (enq_valid),
    .enq_ready (enq_ready),
    .enq_data  (enq_data),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_data  (deq_data)
  );

  // Frame tracker
  dvfa_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .deq_valid        (deq_valid),
    .deq_ready        (deq_ready),
    .deq_data         (deq_data),
    .out_chan         (out_chan)
  );

endmodule

// ===== test/tb_dv_isoc_frame_assembler.sv =====
// ----------------------------------------------------------------------------
// tb_dv_isoc_frame_assembler - self-checking bench for the DV frame assembler
// Streams received isochronous packets into the block: a short directed
// opening, then random packet traffic under several frame sizes. A local
// predictor computes the expected buffer write and status for every accepted
// word, and the monitor compares each result word field by field.
// ----------------------------------------------------------------------------
module tb_dv_isoc_frame_assembler;

  localparam int POS_BITS      = 18;
  localparam int POS_MAX       = (1 << POS_BITS) - 1;
  localparam int FULL_WORDS    = dvfa_pkg::LAST_INDEX + 1;
  localparam int LATENCY_SLACK = 6;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 6_000_000;

  // One received quadlet with its sideband
  typedef struct packed {
    logic [31:0] quadlet;
    logic        first_word;
    logic [15:0] packet_length;
  } rx_word_t;

  // Expected result word: buffer write plus frame/packet status
  typedef struct packed {
    logic                           write_enable;
    logic [dvfa_pkg::ADDR_BITS-1:0] write_address;
    logic [31:0]                    write_data;
    dvfa_pkg::frame_event_t         frame_event;
    dvfa_pkg::packet_error_t        packet_error;
    logic [31:0]                    frame_sequence;
  } buffer_op_t;

  typedef enum int {HDR_GOOD, HDR0_TOP, HDR0_DBS, HDR1_TOP} hdr_fault_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_write_enable;
  logic [dvfa_pkg::SIZE_BITS-1:0] cfg_write_data;

  dvfa_in_if  in_chan ();
  dvfa_out_if out_chan ();

  dv_isoc_frame_assembler #(
    .POSITION_BITS (POS_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_chan          (in_chan),
    .out_chan         (out_chan)
  );

  always #2 clk = ~clk;

  rx_word_t   quadlet_backlog[$];
  buffer_op_t expected_ops[$];
  rx_word_t   on_bus;
  int         mismatches = 0;
  bit         idling_on = 1'b1;
  int         send_gap = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         cycle_count = 0;

  // Predictor state, mirrors the block after reset
  int          pkt_index = 0;
  logic        hdr0_good = 1'b0;
  logic        pkt_live = 1'b0;
  logic        pkt_stores = 1'b0;
  int          frame_pos = 0;
  logic        first_frame_seen = 1'b0;
  logic [31:0] frames_done = '0;
  int          frame_bytes = int'(dvfa_pkg::FRAME_SIZE_RST);

  // Expected result for one accepted word; advances the predictor state
  function automatic buffer_op_t assemble_quadlet(input rx_word_t w);
    buffer_op_t r;
    int idx;
    r = '0;
    idx = w.first_word ? 0 : pkt_index;
    if (w.first_word) begin
      pkt_live = (w.packet_length == dvfa_pkg::HEADER_LENGTH) ||
                 (w.packet_length == dvfa_pkg::FULL_LENGTH);
      pkt_stores = (w.packet_length == dvfa_pkg::FULL_LENGTH);
      hdr0_good = (w.quadlet[31:30] == 2'b00) &&
                  (w.quadlet[23:16] == 8'(dvfa_pkg::CIP_DBS));
      if (!pkt_live) r.packet_error = dvfa_pkg::PERR_BAD_LEN;
    end else if (pkt_live && idx == 1) begin
      if (!(hdr0_good && w.quadlet[31:29] == 3'b100)) begin
        r.packet_error = dvfa_pkg::PERR_BAD_CIP;
        pkt_live = 1'b0;
      end else if (!pkt_stores) begin
        pkt_live = 1'b0;
      end
    end else if (pkt_live && idx >= 2 && idx <= dvfa_pkg::LAST_INDEX) begin
      if (idx == 2) begin
        // DIF block 0 closes the running frame
        if (w.quadlet[31:29] == 3'b000 && w.quadlet[23:19] == 5'd0) begin
          if (!first_frame_seen) begin
            first_frame_seen = 1'b1;
          end else if (frame_pos < frame_bytes) begin
            r.frame_event = dvfa_pkg::EV_UNDERFLOW;
          end else if (frame_pos > frame_bytes) begin
            r.frame_event = dvfa_pkg::EV_OVERFLOW;
          end else begin
            r.frame_event = dvfa_pkg::EV_COMPLETE;
            r.frame_sequence = frames_done;
            frames_done = frames_done + 32'd1;
          end
          frame_pos = 0;
        end
        pkt_stores = (frame_pos + dvfa_pkg::PAYLOAD_BYTES) <= frame_bytes;
      end
      if (pkt_stores) begin
        r.write_enable = 1'b1;
        r.write_address = dvfa_pkg::ADDR_BITS'(frame_pos + 4 * (idx - 2));
        r.write_data = w.quadlet;
      end
      if (idx == dvfa_pkg::LAST_INDEX) begin
        frame_pos = (frame_pos > POS_MAX - dvfa_pkg::PAYLOAD_BYTES) ?
                    POS_MAX : frame_pos + dvfa_pkg::PAYLOAD_BYTES;
        pkt_live = 1'b0;
      end
    end
    pkt_index = (idx < 127) ? idx + 1 : 127;
    return r;
  endfunction

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic take_result();
    buffer_op_t want;
    if (expected_ops.size() == 0) begin
      $error("result word with nothing expected");
      mismatches++;
    end else begin
      want = expected_ops.pop_front();
      compare_field("write_enable", want.write_enable, out_chan.write_enable);
      compare_field("write_address", want.write_address, out_chan.write_address);
      compare_field("write_data", want.write_data, out_chan.write_data);
      compare_field("frame_event", want.frame_event, out_chan.frame_event);
      compare_field("packet_error", want.packet_error, out_chan.packet_error);
      compare_field("frame_sequence", want.frame_sequence, out_chan.frame_sequence);
    end
  endtask

  // Driver: predicts on acceptance, holds a word until taken, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) expected_ops.push_back(assemble_quadlet(on_bus));
      if (!(in_chan.valid && !in_chan.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (quadlet_backlog.size() == 0) begin
          in_chan.valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(1, 11) - 1;
          in_chan.valid <= 1'b0;
        end else begin
          on_bus = quadlet_backlog.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.quadlet <= on_bus.quadlet;
          in_chan.first_word <= on_bus.first_word;
          in_chan.packet_length <= on_bus.packet_length;
        end
      end
    end
  end

  // Monitor: checks each taken word, stalls at random, long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) take_result();
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic push_word(input logic [31:0] q, input logic first, input logic [15:0] len);
    rx_word_t w;
    w.quadlet = q;
    w.first_word = first;
    w.packet_length = len;
    quadlet_backlog.push_back(w);
  endtask

  function automatic logic [31:0] cip_header0(input hdr_fault_t fault);
    logic [31:0] h;
    h = $urandom();
    h[31:30] = 2'b00;
    h[23:16] = 8'(dvfa_pkg::CIP_DBS);
    if (fault == HDR0_TOP) h[31:30] = 2'($urandom_range(1, 3));
    else if (fault == HDR0_DBS)
      while (h[23:16] == 8'(dvfa_pkg::CIP_DBS)) h[23:16] = 8'($urandom());
    return h;
  endfunction

  function automatic logic [31:0] cip_header1(input hdr_fault_t fault);
    logic [31:0] h;
    h = $urandom();
    h[31:29] = 3'b100;
    if (fault == HDR1_TOP)
      while (h[31:29] == 3'b100) h[31:29] = 3'($urandom());
    return h;
  endfunction

  // First payload word: DIF header, block 0 or any other block
  function automatic logic [31:0] dif_header(input bit block_zero);
    logic [31:0] q;
    q = $urandom();
    if (block_zero) begin
      q[31:29] = 3'b000;
      q[23:19] = 5'd0;
    end else if (q[31:29] == 3'b000 && q[23:19] == 5'd0) begin
      q[19] = 1'b1;
    end
    return q;
  endfunction

  function automatic logic [15:0] bad_length();
    logic [15:0] l;
    l = 16'($urandom());
    while (l == dvfa_pkg::HEADER_LENGTH || l == dvfa_pkg::FULL_LENGTH) l = 16'($urandom());
    return l;
  endfunction

  // Length is only meaningful on the first word; elsewhere it is noise
  task automatic push_packet(input logic [15:0] len, input hdr_fault_t fault,
                             input bit block_zero, input int n_words);
    for (int i = 0; i < n_words; i++) begin
      if (i == 0) push_word(cip_header0(fault), 1'b1, len);
      else if (i == 1) push_word(cip_header1(fault), 1'b0, 16'($urandom()));
      else if (i == 2) push_word(dif_header(block_zero), 1'b0, 16'($urandom()));
      else push_word($urandom(), 1'b0, 16'($urandom()));
    end
  endtask

  // Mostly well-formed frames of frame_pkts packets, with cut, short,
  // overlong and broken packets mixed in
  task automatic run_traffic(input int word_budget, input int frame_pkts);
    int sent;
    int since_b0;
    int pick;
    int n;
    bit b0;
    hdr_fault_t fault;
    sent = 0;
    since_b0 = frame_pkts;
    while (sent < word_budget) begin
      pick = $urandom_range(0, 99);
      b0 = (since_b0 >= frame_pkts) ? ($urandom_range(0, 7) != 0)
                                    : ($urandom_range(0, 11) == 0);
      if (pick < 70) begin
        n = FULL_WORDS;
        if ($urandom_range(0, 9) == 0) n += $urandom_range(1, 12);
        push_packet(16'(dvfa_pkg::FULL_LENGTH), HDR_GOOD, b0, n);
        since_b0 = b0 ? 1 : since_b0 + 1;
      end else if (pick < 80) begin
        n = $urandom_range(1, FULL_WORDS - 1);
        push_packet(16'(dvfa_pkg::FULL_LENGTH), HDR_GOOD, b0, n);
      end else if (pick < 88) begin
        n = $urandom_range(1, 4);
        push_packet(16'(dvfa_pkg::HEADER_LENGTH), HDR_GOOD, 1'b0, n);
      end else if (pick < 95) begin
        n = $urandom_range(1, 6);
        fault = hdr_fault_t'($urandom_range(1, 3));
        push_packet($urandom_range(0, 1) ? 16'(dvfa_pkg::FULL_LENGTH)
                                         : 16'(dvfa_pkg::HEADER_LENGTH),
                    fault, b0, n);
      end else begin
        n = $urandom_range(1, 6);
        push_packet(bad_length(), HDR_GOOD, b0, n);
      end
      sent += n;
    end
  endtask

  // Wait until every word is taken and checked, then let the pipe empty
  task automatic settle();
    while (quadlet_backlog.size() != 0 || in_chan.valid || expected_ops.size() != 0)
      @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  task automatic set_frame_size(input logic [dvfa_pkg::SIZE_BITS-1:0] bytes);
    settle();
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= bytes;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    frame_bytes = int'(bytes);
  endtask

  // Stimulus
  initial begin
    rst_n = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    in_chan.valid = 1'b0;
    in_chan.quadlet = '0;
    in_chan.first_word = 1'b0;
    in_chan.packet_length = '0;
    out_chan.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Words before any packet start are ignored
    push_word(32'h0000_0000, 1'b0, 16'h0000);
    push_word(32'hffff_ffff, 1'b0, 16'hffff);
    // Bad length status at both ends of the field
    push_packet(16'h0000, HDR_GOOD, 1'b0, 2);
    push_packet(16'hffff, HDR_GOOD, 1'b0, 2);
    // Header-only packets, good and with each fault; a full-length one with bad header 1
    push_packet(16'(dvfa_pkg::HEADER_LENGTH), HDR_GOOD, 1'b0, 2);
    push_packet(16'(dvfa_pkg::HEADER_LENGTH), HDR0_TOP, 1'b0, 2);
    push_packet(16'(dvfa_pkg::HEADER_LENGTH), HDR0_DBS, 1'b0, 2);
    push_packet(16'(dvfa_pkg::HEADER_LENGTH), HDR1_TOP, 1'b0, 2);
    push_packet(16'(dvfa_pkg::FULL_LENGTH), HDR1_TOP, 1'b0, 2);
    // Cut packets: first block 0 ever, then block 0 again on an empty frame
    push_packet(16'(dvfa_pkg::FULL_LENGTH), HDR_GOOD, 1'b1, 5);
    push_packet(16'(dvfa_pkg::FULL_LENGTH), HDR_GOOD, 1'b1, 3);

    run_traffic(150, 2);

    // One-packet frame, with the result side held off to back up the input
    set_frame_size(18'(dvfa_pkg::PAYLOAD_BYTES));
    hold_requests++;
    run_traffic(450, 1);

    set_frame_size(18'(2 * dvfa_pkg::PAYLOAD_BYTES));
    run_traffic(300, 2);

    set_frame_size(18'd0);
    run_traffic(120, 1);

    set_frame_size(18'($urandom_range(dvfa_pkg::PAYLOAD_BYTES, 262080)));
    run_traffic(120, 2);

    // Closing stretch at full rate
    set_frame_size(18'(dvfa_pkg::PAYLOAD_BYTES));
    idling_on = 1'b0;
    run_traffic(350, 1);

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
